FILE: rtl/caldate_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and calendar functions for the calendar date counter.
// No dependencies; used by caldate_ctrl, caldate_dp and the top level.
package caldate_pkg;

    localparam int unsigned DAY_W   = 5;
    localparam int unsigned MONTH_W = 4;
    localparam int unsigned YEAR_W  = 12;
    localparam int unsigned CNT_W   = 16;

    localparam logic [YEAR_W-1:0]  YEAR_RST  = 12'd1900;
    localparam logic [YEAR_W-1:0]  YEAR_MIN  = 12'd1900;
    localparam logic [YEAR_W-1:0]  YEAR_MAX  = 12'd2100;
    localparam logic [MONTH_W-1:0] MONTH_MIN = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_MAX = 4'd12;
    localparam logic [DAY_W-1:0]   DAY_MIN   = 5'd1;
    localparam logic [DAY_W-1:0]   DAY_FEB_LEAP = 5'd29;

    // Request kinds
    localparam logic KIND_SET = 1'b0;
    localparam logic KIND_ADV = 1'b1;

    // Month lengths, index 0 unused (reads as 31)
    localparam logic [DAY_W-1:0] MONTH_LEN [16] = '{
        5'd31, 5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31,
        5'd31, 5'd30, 5'd31, 5'd30, 5'd31, 5'd31, 5'd31, 5'd31
    };

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_FIN
    } t_state;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_SET,
        OP_ADV_START,
        OP_STEP
    } t_op;

    typedef struct packed {
        t_op  op;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic start_last;   // incoming advance count is 0 or 1
        logic run_last;     // one day left to step
    } t_status;

    typedef struct packed {
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
        logic [YEAR_W-1:0]  year;
    } t_date;

    // Multiples of 100 are all multiples of 4, so leap means: low two bits
    // clear and not a century year unless a multiple of 400.
    function automatic logic is_leap(input logic [YEAR_W-1:0] y);
        logic cent;
        logic quad;
        cent = 1'b0;
        quad = 1'b0;
        for (int i = 0; i <= 40; i++) begin
            if (y == YEAR_W'(i * 100)) begin
                cent = 1'b1;
                if ((i % 4) == 0) begin
                    quad = 1'b1;
                end
            end
        end
        return (y[1:0] == 2'b00) && (!cent || quad);
    endfunction

    function automatic logic [DAY_W-1:0] days_in(input logic [MONTH_W-1:0] m,
                                                 input logic [YEAR_W-1:0] y);
        logic [DAY_W-1:0] len;
        len = MONTH_LEN[m];
        if (m == 4'd2 && is_leap(y)) begin
            len = DAY_FEB_LEAP;
        end
        return len;
    endfunction

endpackage

FILE: rtl/calendar_date_counter_top.sv
`timescale 1ns / 1ps
// Top level of the Gregorian calendar date counter.
// Depends on caldate_pkg, caldate_ctrl and caldate_dp.
//
//  channel | valid       | stall       | payload
//  --------+-------------+-------------+------------------------------------------
//  input   | i_in_valid  | o_in_stall  | i_kind, i_new_month, i_new_day,
//          |             |             | i_new_year, i_advance_count
//  output  | o_out_valid | i_out_stall | o_prior_month/day/year,
//          |             |             | o_month_now, o_day_now, o_year_now
//
// A set request is applied in its accept cycle; an advance by N days takes
// one pass through the day step unit per day.
// A new request is accepted the cycle after the previous one finishes.
// Reset (synchronous) loads 1 January 1900 and empties the output register.
// If the output register is still full and stalled at finish, the controller
// holds the result and stalls the input until the register is taken.
module calendar_date_counter_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic                                i_kind,
    input  logic [caldate_pkg::MONTH_W-1:0]     i_new_month,
    input  logic [caldate_pkg::DAY_W-1:0]       i_new_day,
    input  logic [caldate_pkg::YEAR_W-1:0]      i_new_year,
    input  logic [caldate_pkg::CNT_W-1:0]       i_advance_count,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [caldate_pkg::MONTH_W-1:0]     o_prior_month,
    output logic [caldate_pkg::DAY_W-1:0]       o_prior_day,
    output logic [caldate_pkg::YEAR_W-1:0]      o_prior_year,
    output logic [caldate_pkg::MONTH_W-1:0]     o_month_now,
    output logic [caldate_pkg::DAY_W-1:0]       o_day_now,
    output logic [caldate_pkg::YEAR_W-1:0]      o_year_now
);

    caldate_pkg::t_cmd    cmd;
    caldate_pkg::t_status status;

    caldate_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_kind      (i_kind),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    caldate_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_new_month     (i_new_month),
        .i_new_day       (i_new_day),
        .i_new_year      (i_new_year),
        .i_advance_count (i_advance_count),
        .i_cmd           (cmd),
        .o_status        (status),
        .o_prior_month   (o_prior_month),
        .o_prior_day     (o_prior_day),
        .o_prior_year    (o_prior_year),
        .o_month_now     (o_month_now),
        .o_day_now       (o_day_now),
        .o_year_now      (o_year_now)
    );

endmodule

FILE: rtl/caldate_ctrl.sv
`timescale 1ns / 1ps
// Controller for the calendar date counter: handshakes, step sequencing,
// output valid. Depends on caldate_pkg.
module caldate_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic                 i_kind,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    input  caldate_pkg::t_status i_status,
    output caldate_pkg::t_cmd    o_cmd
);

    caldate_pkg::t_state r_state;
    caldate_pkg::t_state n_state;
    logic                r_out_valid;
    logic                n_out_valid;
    logic                in_acc;
    logic                slot_free;
    logic                finish;

    assign in_acc    = i_in_valid && (r_state == caldate_pkg::ST_IDLE);
    assign slot_free = !r_out_valid || !i_out_stall;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            caldate_pkg::ST_IDLE: begin
                if (in_acc) begin
                    if (i_kind == caldate_pkg::KIND_ADV && !i_status.start_last) begin
                        n_state = caldate_pkg::ST_RUN;
                    end else if (!slot_free) begin
                        n_state = caldate_pkg::ST_FIN;
                    end
                end
            end
            caldate_pkg::ST_RUN: begin
                if (i_status.run_last) begin
                    n_state = slot_free ? caldate_pkg::ST_IDLE : caldate_pkg::ST_FIN;
                end
            end
            caldate_pkg::ST_FIN: begin
                if (slot_free) begin
                    n_state = caldate_pkg::ST_IDLE;
                end
            end
            default: n_state = caldate_pkg::ST_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        o_cmd.op = caldate_pkg::OP_NONE;
        finish   = 1'b0;
        unique case (r_state)
            caldate_pkg::ST_IDLE: begin
                if (in_acc) begin
                    if (i_kind == caldate_pkg::KIND_ADV) begin
                        o_cmd.op = caldate_pkg::OP_ADV_START;
                        finish   = i_status.start_last;
                    end else begin
                        o_cmd.op = caldate_pkg::OP_SET;
                        finish   = 1'b1;
                    end
                end
            end
            caldate_pkg::ST_RUN: begin
                o_cmd.op = caldate_pkg::OP_STEP;
                finish   = i_status.run_last;
            end
            caldate_pkg::ST_FIN: begin
                finish = 1'b1;
            end
            default: begin
                o_cmd.op = caldate_pkg::OP_NONE;
                finish   = 1'b0;
            end
        endcase
        o_cmd.load_out = finish && slot_free;
        n_out_valid    = o_cmd.load_out || (r_out_valid && i_out_stall);
        o_in_stall     = (r_state != caldate_pkg::ST_IDLE);
        o_out_valid    = r_out_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= caldate_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

FILE: rtl/caldate_dp.sv
`timescale 1ns / 1ps
// Datapath for the calendar date counter: date register, set validation,
// one-day step unit, day counter and output register. Depends on caldate_pkg.
module caldate_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic [caldate_pkg::MONTH_W-1:0]     i_new_month,
    input  logic [caldate_pkg::DAY_W-1:0]       i_new_day,
    input  logic [caldate_pkg::YEAR_W-1:0]      i_new_year,
    input  logic [caldate_pkg::CNT_W-1:0]       i_advance_count,
    input  caldate_pkg::t_cmd                   i_cmd,
    output caldate_pkg::t_status                o_status,
    output logic [caldate_pkg::MONTH_W-1:0]     o_prior_month,
    output logic [caldate_pkg::DAY_W-1:0]       o_prior_day,
    output logic [caldate_pkg::YEAR_W-1:0]      o_prior_year,
    output logic [caldate_pkg::MONTH_W-1:0]     o_month_now,
    output logic [caldate_pkg::DAY_W-1:0]       o_day_now,
    output logic [caldate_pkg::YEAR_W-1:0]      o_year_now
);

    caldate_pkg::t_date              r_date;
    caldate_pkg::t_date              n_date;
    caldate_pkg::t_date              r_prior;
    caldate_pkg::t_date              n_prior;
    caldate_pkg::t_date              r_out_prior;
    caldate_pkg::t_date              r_out_now;
    caldate_pkg::t_date              step_date;
    caldate_pkg::t_date              set_date;
    logic [caldate_pkg::CNT_W-1:0]   r_cnt;
    logic [caldate_pkg::CNT_W-1:0]   n_cnt;
    logic [caldate_pkg::DAY_W-1:0]   set_lim;
    logic                            live_prior;

    // One-day step with month and year rollover; year wraps at its width
    always_comb begin
        step_date = r_date;
        if (r_date.day >= caldate_pkg::days_in(r_date.month, r_date.year)) begin
            step_date.day = caldate_pkg::DAY_MIN;
            if (r_date.month >= caldate_pkg::MONTH_MAX) begin
                step_date.month = caldate_pkg::MONTH_MIN;
                step_date.year  = r_date.year + 1'b1;
            end else begin
                step_date.month = r_date.month + 1'b1;
            end
        end else begin
            step_date.day = r_date.day + 1'b1;
        end
    end

    // Set validation: month, then year, then day against the checked month
    always_comb begin
        set_date.month = (i_new_month >= caldate_pkg::MONTH_MIN &&
                          i_new_month <= caldate_pkg::MONTH_MAX) ?
                         i_new_month : caldate_pkg::MONTH_MIN;
        set_date.year  = (i_new_year >= caldate_pkg::YEAR_MIN &&
                          i_new_year <= caldate_pkg::YEAR_MAX) ?
                         i_new_year : caldate_pkg::YEAR_MIN;
        set_lim        = caldate_pkg::days_in(set_date.month, set_date.year);
        set_date.day   = (i_new_day >= caldate_pkg::DAY_MIN && i_new_day <= set_lim) ?
                         i_new_day : caldate_pkg::DAY_MIN;
    end

    always_comb begin
        n_date     = r_date;
        n_prior    = r_prior;
        n_cnt      = r_cnt;
        live_prior = 1'b0;
        unique case (i_cmd.op)
            caldate_pkg::OP_NONE: begin
                n_date = r_date;
            end
            caldate_pkg::OP_SET: begin
                n_date     = set_date;
                n_prior    = r_date;
                live_prior = 1'b1;
            end
            caldate_pkg::OP_ADV_START: begin
                // first day is stepped in the accept cycle
                if (i_advance_count != '0) begin
                    n_date = step_date;
                end
                n_cnt      = i_advance_count - 1'b1;
                n_prior    = r_date;
                live_prior = 1'b1;
            end
            caldate_pkg::OP_STEP: begin
                n_date = step_date;
                n_cnt  = r_cnt - 1'b1;
            end
            default: n_date = r_date;
        endcase
    end

    assign o_status.start_last = (i_advance_count <= caldate_pkg::CNT_W'(1));
    assign o_status.run_last   = (r_cnt == caldate_pkg::CNT_W'(1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_date.day   <= caldate_pkg::DAY_MIN;
            r_date.month <= caldate_pkg::MONTH_MIN;
            r_date.year  <= caldate_pkg::YEAR_RST;
        end else begin
            r_date <= n_date;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prior <= n_prior;
        r_cnt   <= n_cnt;
        if (i_cmd.load_out) begin
            r_out_prior <= live_prior ? r_date : r_prior;
            r_out_now   <= n_date;
        end
    end

    assign o_prior_month = r_out_prior.month;
    assign o_prior_day   = r_out_prior.day;
    assign o_prior_year  = r_out_prior.year;
    assign o_month_now   = r_out_now.month;
    assign o_day_now     = r_out_now.day;
    assign o_year_now    = r_out_now.year;

endmodule

FILE: rtl/caldate_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the calendar date counter, bound to the top level.
// Depends on caldate_pkg and calendar_date_counter_top.
module caldate_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_in_valid,
    input logic                                o_in_stall,
    input logic                                i_kind,
    input logic                                o_out_valid,
    input logic                                i_out_stall,
    input logic [caldate_pkg::MONTH_W-1:0]     o_month_now,
    input logic [caldate_pkg::DAY_W-1:0]       o_day_now,
    input logic [caldate_pkg::YEAR_W-1:0]      o_year_now
);

    // result held while stalled
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid &&
        $stable(o_month_now) && $stable(o_day_now) && $stable(o_year_now))
        else $error("stalled result changed or dropped");

    // month and day of a result are always in calendar range
    a_now_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_month_now >= 4'd1 && o_month_now <= 4'd12 &&
                        o_day_now >= 5'd1 && o_day_now <= 5'd31)
        else $error("result date out of range");

    // a set request with an empty output slot shows its result next cycle, year clamped
    a_set_fast: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && i_kind == caldate_pkg::KIND_SET && !o_out_valid
        |=> o_out_valid && o_year_now >= 12'd1900 && o_year_now <= 12'd2100)
        else $error("set request result late or year not clamped");

    // from idle with an empty slot, a result only shows up after a request
    a_stall_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid && !o_in_stall |=> !o_out_valid || $past(i_in_valid))
        else $error("result appeared without a request");

endmodule

bind calendar_date_counter_top caldate_checker u_caldate_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_kind      (i_kind),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_month_now (o_month_now),
    .o_day_now   (o_day_now),
    .o_year_now  (o_year_now)
);

FILE: dv/calendar_date_counter_top_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for calendar_date_counter_top: queue-fed request driver,
// result monitor and an in-bench date predictor. Depends on caldate_pkg and the RTL.
module calendar_date_counter_top_tb;

    typedef struct {
        logic                            kind;
        logic [caldate_pkg::MONTH_W-1:0] month;
        logic [caldate_pkg::DAY_W-1:0]   day;
        logic [caldate_pkg::YEAR_W-1:0]  year;
        logic [caldate_pkg::CNT_W-1:0]   count;
        int                              gap;     // idle cycles before the request
        bit                              drain;   // hold until all results are back
    } t_date_req;

    typedef struct {
        caldate_pkg::t_date before_d;
        caldate_pkg::t_date after_d;
    } t_date_pair;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            i_in_valid = 1'b0;
    logic                            o_in_stall;
    logic                            i_kind = caldate_pkg::KIND_SET;
    logic [caldate_pkg::MONTH_W-1:0] i_new_month = '0;
    logic [caldate_pkg::DAY_W-1:0]   i_new_day = '0;
    logic [caldate_pkg::YEAR_W-1:0]  i_new_year = '0;
    logic [caldate_pkg::CNT_W-1:0]   i_advance_count = '0;
    logic                            o_out_valid;
    logic                            i_out_stall = 1'b0;
    logic [caldate_pkg::MONTH_W-1:0] o_prior_month;
    logic [caldate_pkg::DAY_W-1:0]   o_prior_day;
    logic [caldate_pkg::YEAR_W-1:0]  o_prior_year;
    logic [caldate_pkg::MONTH_W-1:0] o_month_now;
    logic [caldate_pkg::DAY_W-1:0]   o_day_now;
    logic [caldate_pkg::YEAR_W-1:0]  o_year_now;

    t_date_req          date_req_q[$];
    t_date_pair         date_pair_q[$];
    t_date_req          cur_req;
    caldate_pkg::t_date tb_date;
    int                 fail_count = 0;
    int                 gap_left = 0;
    bit                 gap_armed = 1'b0;
    int                 stall_left = 0;
    int                 mode_left = 0;
    bit                 noisy = 1'b0;
    int                 n_total = 0;
    int                 n_accepted = 0;

    calendar_date_counter_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_kind          (i_kind),
        .i_new_month     (i_new_month),
        .i_new_day       (i_new_day),
        .i_new_year      (i_new_year),
        .i_advance_count (i_advance_count),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_prior_month   (o_prior_month),
        .o_prior_day     (o_prior_day),
        .o_prior_year    (o_prior_year),
        .o_month_now     (o_month_now),
        .o_day_now       (o_day_now),
        .o_year_now      (o_year_now)
    );

    always #1 i_clk = ~i_clk;

    function automatic bit leap_year(input logic [caldate_pkg::YEAR_W-1:0] y);
        return (y % 400 == 0) || ((y % 100 != 0) && (y % 4 == 0));
    endfunction

    function automatic logic [caldate_pkg::DAY_W-1:0] month_days(
        input logic [caldate_pkg::MONTH_W-1:0] m,
        input logic [caldate_pkg::YEAR_W-1:0] y);
        case (m)
            4'd2: return leap_year(y) ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11: return 5'd30;
            default: return 5'd31;
        endcase
    endfunction

    function automatic caldate_pkg::t_date day_after(input caldate_pkg::t_date d);
        caldate_pkg::t_date nd;
        nd = d;
        if (d.day >= month_days(d.month, d.year)) begin
            nd.day = 5'd1;
            if (d.month >= 4'd12) begin
                nd.month = 4'd1;
                nd.year = d.year + 1'b1;    // wraps 4095 -> 0
            end else begin
                nd.month = d.month + 1'b1;
            end
        end else begin
            nd.day = d.day + 1'b1;
        end
        return nd;
    endfunction

    function automatic caldate_pkg::t_date apply_date_req(input caldate_pkg::t_date d,
                                                          input t_date_req r);
        caldate_pkg::t_date              nd;
        logic [caldate_pkg::MONTH_W-1:0] mo;
        logic [caldate_pkg::YEAR_W-1:0]  yr;
        nd = d;
        if (r.kind == caldate_pkg::KIND_SET) begin
            mo = (r.month >= 1 && r.month <= 12) ? r.month : 4'd1;
            yr = (r.year >= 1900 && r.year <= 2100) ? r.year : 12'd1900;
            nd.month = mo;
            nd.year = yr;
            nd.day = (r.day >= 1 && r.day <= month_days(mo, yr)) ? r.day : 5'd1;
        end else begin
            for (int i = 0; i < r.count; i++) begin
                nd = day_after(nd);
            end
        end
        return nd;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic add_req(input logic kind, input int m, input int d, input int y,
                           input int cnt, input int gap, input bit drain);
        t_date_req r;
        r.kind = kind;
        r.month = caldate_pkg::MONTH_W'(m);
        r.day = caldate_pkg::DAY_W'(d);
        r.year = caldate_pkg::YEAR_W'(y);
        r.count = caldate_pkg::CNT_W'(cnt);
        r.gap = gap;
        r.drain = drain;
        date_req_q.push_back(r);
    endtask

    // Request driver: predicts on acceptance, then pulls the next request.
    always @(posedge i_clk) begin
        t_date_pair exp_pair;
        logic       presenting;
        presenting = i_in_valid;
        if (!i_rst_n) begin
            presenting = 1'b0;
            gap_left = 0;
            gap_armed = 1'b0;
            tb_date.month = 4'd1;
            tb_date.day = 5'd1;
            tb_date.year = 12'd1900;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                exp_pair.before_d = tb_date;
                tb_date = apply_date_req(tb_date, cur_req);
                exp_pair.after_d = tb_date;
                date_pair_q.push_back(exp_pair);
                n_accepted++;
                presenting = 1'b0;
            end
            if (!presenting && date_req_q.size() > 0) begin
                if (!gap_armed) begin
                    gap_left = date_req_q[0].gap;
                    gap_armed = 1'b1;
                end
                if (gap_left > 0) begin
                    gap_left--;
                end else if (!date_req_q[0].drain || date_pair_q.size() == 0) begin
                    cur_req = date_req_q.pop_front();
                    i_kind <= cur_req.kind;
                    i_new_month <= cur_req.month;
                    i_new_day <= cur_req.day;
                    i_new_year <= cur_req.year;
                    i_advance_count <= cur_req.count;
                    presenting = 1'b1;
                    gap_armed = 1'b0;
                end
            end
        end
        i_in_valid <= presenting;
    end

    task automatic compare_field(input string name, input int exp_v, input int act_v);
        if (exp_v != act_v) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
            fail_count++;
        end
    endtask

    // Result monitor with random stall bursts, alternating calm and noisy stretches.
    always @(posedge i_clk) begin
        t_date_pair exp_pair;
        logic       stall_next;
        int         r;
        stall_next = 1'b0;
        if (!i_rst_n) begin
            stall_left = 0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (date_pair_q.size() == 0) begin
                    $display({"%0t: unexpected result, expected none, ",
                              "got %0d/%0d/%0d -> %0d/%0d/%0d"},
                             $time, o_prior_month, o_prior_day, o_prior_year,
                             o_month_now, o_day_now, o_year_now);
                    fail_count++;
                end else begin
                    exp_pair = date_pair_q.pop_front();
                    compare_field("prior_month", exp_pair.before_d.month, o_prior_month);
                    compare_field("prior_day", exp_pair.before_d.day, o_prior_day);
                    compare_field("prior_year", exp_pair.before_d.year, o_prior_year);
                    compare_field("month_now", exp_pair.after_d.month, o_month_now);
                    compare_field("day_now", exp_pair.after_d.day, o_day_now);
                    compare_field("year_now", exp_pair.after_d.year, o_year_now);
                end
            end
            if (mode_left == 0) begin
                noisy = !noisy;
                mode_left = $urandom_range(50, 400);
            end else begin
                mode_left--;
            end
            if (stall_left > 0) begin
                stall_left--;
                stall_next = 1'b1;
            end else if (noisy) begin
                r = $urandom_range(0, 99);
                if (r < 2) begin
                    stall_left = $urandom_range(20, 60);
                end else if (r < 20) begin
                    stall_left = $urandom_range(1, 3);
                end
            end
        end
        i_out_stall <= stall_next;
    end

    initial begin
        int remaining;
        int m;
        int y;
        int len;
        int d;
        int gap;
        int r;
        int cnt;

        // validation of set requests
        add_req(caldate_pkg::KIND_SET, 0, 0, 0, 16'hFFFF, 0, 0);
        add_req(caldate_pkg::KIND_SET, 15, 31, 4095, 0, 0, 0);
        add_req(caldate_pkg::KIND_SET, 13, 15, 2000, 0, 0, 0);
        add_req(caldate_pkg::KIND_SET, 12, 31, 1899, 0, 0, 0);
        add_req(caldate_pkg::KIND_SET, 6, 15, 2101, 0, 0, 0);
        add_req(caldate_pkg::KIND_SET, 4, 31, 2024, 0, 0, 0);
        add_req(caldate_pkg::KIND_SET, 2, 29, 1900, 0, 0, 0);
        add_req(caldate_pkg::KIND_SET, 2, 29, 2100, 0, 0, 0);
        add_req(caldate_pkg::KIND_SET, 2, 30, 2000, 0, 0, 0);
        // month, year and leap-day rollover
        add_req(caldate_pkg::KIND_SET, 12, 31, 2100, 0, 0, 0);
        add_req(caldate_pkg::KIND_ADV, 15, 31, 4095, 1, 0, 0);
        add_req(caldate_pkg::KIND_SET, 2, 28, 2000, 0, 0, 0);
        add_req(caldate_pkg::KIND_ADV, 0, 0, 0, 1, 0, 0);
        add_req(caldate_pkg::KIND_ADV, 0, 0, 0, 1, 0, 0);
        add_req(caldate_pkg::KIND_SET, 2, 28, 1900, 0, 0, 0);
        add_req(caldate_pkg::KIND_ADV, 0, 0, 0, 1, 0, 0);
        add_req(caldate_pkg::KIND_SET, 4, 30, 2023, 0, 0, 0);
        add_req(caldate_pkg::KIND_ADV, 15, 31, 4095, 0, 0, 0);
        add_req(caldate_pkg::KIND_ADV, 0, 0, 0, 1, 0, 0);
        add_req(caldate_pkg::KIND_ADV, 0, 0, 0, 400, 0, 0);

        // run the year counter past 4095 and on to Feb 29 of year 0
        add_req(caldate_pkg::KIND_SET, 12, 31, 2100, 0, 0, 1);
        remaining = 60;
        for (int yy = 2101; yy <= 4095; yy++) begin
            remaining += leap_year(caldate_pkg::YEAR_W'(yy)) ? 366 : 365;
        end
        while (remaining > 65535) begin
            add_req(caldate_pkg::KIND_ADV, 0, 0, 0, 65535, 0, 0);
            remaining -= 65535;
        end
        add_req(caldate_pkg::KIND_ADV, 0, 0, 0, remaining, 0, 0);
        add_req(caldate_pkg::KIND_ADV, 0, 0, 0, 1, 0, 0);

        for (int n = 0; n < 800; n++) begin
            // every so often a run of back-to-back requests
            gap = ((n / 50) % 3 == 1) ? 0 : pick_gap();
            r = $urandom_range(0, 99);
            if (r < 45) begin
                if ($urandom_range(0, 99) < 25) begin
                    add_req(caldate_pkg::KIND_SET, $urandom_range(0, 15),
                            $urandom_range(0, 31), $urandom_range(0, 4095),
                            $urandom_range(0, 65535), gap, 0);
                end else begin
                    m = $urandom_range(1, 12);
                    case ($urandom_range(0, 5))
                        0: y = 1900;
                        1: y = 2000;
                        2: y = 2100;
                        3: y = 4 * $urandom_range(475, 525);
                        default: y = $urandom_range(1900, 2100);
                    endcase
                    len = month_days(caldate_pkg::MONTH_W'(m), caldate_pkg::YEAR_W'(y));
                    if ($urandom_range(0, 99) < 40) begin
                        d = $urandom_range(len - 1, (len + 2 > 31) ? 31 : len + 2);
                    end else begin
                        d = $urandom_range(1, len);
                    end
                    add_req(caldate_pkg::KIND_SET, m, d, y, $urandom_range(0, 65535),
                            gap, 0);
                end
            end else begin
                r = $urandom_range(0, 99);
                if (r < 55) begin
                    cnt = $urandom_range(0, 3);
                end else if (r < 85) begin
                    cnt = $urandom_range(4, 64);
                end else if (r < 97) begin
                    cnt = $urandom_range(65, 1500);
                end else begin
                    cnt = $urandom_range(1500, 3000);
                end
                add_req(caldate_pkg::KIND_ADV, $urandom_range(0, 15), $urandom_range(0, 31),
                        $urandom_range(0, 4095), cnt, gap, $urandom_range(0, 99) < 2);
            end
        end
        n_total = date_req_q.size();

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // done once every request was taken and every result came back
        while (n_accepted < n_total || date_pair_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (20) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("calendar_date_counter_top verification clean");
        end else begin
            $display("calendar_date_counter_top verification failed");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("calendar_date_counter_top verification failed");
        $finish;
    end

endmodule
